FILE: sv/wdch_pkg.sv
// ----------------------------------------------------------------------------
// Duty-cycle hysteresis package
// Shared widths, register codes, reset values and control structs.
// ----------------------------------------------------------------------------
package wdch_pkg;

	localparam int CHANNELS_DEF = 5;
	localparam int CHANNELS_MAX = 16;
	localparam int OUT_CHANS    = 5;
	localparam int PIN_W        = 5;
	localparam int CNT_W        = 16;
	localparam int DUTY_W       = 7;
	localparam int PCT_W        = 7;
	localparam int PCT_SCALE    = 100;
	localparam int DVD_W        = CNT_W + DUTY_W;
	localparam int BIT_W        = $clog2(DVD_W);
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_PACK_W   = OUT_CHANS * DUTY_W + 2 * OUT_CHANS;
	localparam int OUT_TDATA_W  = ((OUT_PACK_W + 7) / 8) * 8;
	localparam int APB_AW       = 5;
	localparam int APB_DW       = 32;

	localparam logic [CNT_W-1:0] WINDOW_RST   = CNT_W'(100);
	localparam logic [PCT_W-1:0] ON_RST       = PCT_W'(20);
	localparam logic [PCT_W-1:0] OFF_RST      = PCT_W'(10);
	localparam logic [PCT_W-1:0] FULL_ON_RST  = PCT_W'(90);
	localparam logic [PCT_W-1:0] FULL_OFF_RST = PCT_W'(80);

	typedef enum logic [2:0] {
		REG_WINDOW   = 3'd0,
		REG_ON       = 3'd1,
		REG_OFF      = 3'd2,
		REG_FULL_ON  = 3'd3,
		REG_FULL_OFF = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] window;
		logic [PCT_W-1:0] on_pct;
		logic [PCT_W-1:0] off_pct;
		logic [PCT_W-1:0] full_on_pct;
		logic [PCT_W-1:0] full_off_pct;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic store;
		logic push;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic close_hit;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/windowed_duty_cycle_hysteresis_unit.sv
// ----------------------------------------------------------------------------
// Windowed duty-cycle hysteresis unit
// Counts high samples per channel, divides at window end, applies hysteresis.
// ----------------------------------------------------------------------------
// A sample that does not close a window goes through the push state to the output
// register; a window-closing sample first runs load, iterate and store per channel:
// one shared restoring divider retires one quotient bit per cycle, 23 per channel.
// A new sample is taken only in idle, once the last one is through. A word waiting in
// the output register holds off the next sample only once that sample's word is ready.
// Reset clears counts, duties, flags and output valid; registers take reset values.
module windowed_duty_cycle_hysteresis_unit #(
	parameter int CHANNELS = wdch_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wdch_pkg::IN_TDATA_W-1:0]   s_tdata,  // [4:0] pin_levels
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [6:0] duty_ch0, [13:7] duty_ch1, [20:14] duty_ch2, [27:21] duty_ch3,
	// [34:28] duty_ch4, [39:35] active_mask, [44:40] full_mask
	output logic [wdch_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                        m_tuser,  // [0] window_done
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wdch_pkg::APB_AW-1:0]       paddr,
	input  logic [wdch_pkg::APB_DW-1:0]       pwdata,
	output logic [wdch_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);
	import wdch_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t            cfg;
	cmd_t            cmd;
	sts_t            sts;
	logic [CH_W-1:0] ch_sel;

	wdch_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wdch_ctrl #(
		.CHANNELS (CHANNELS),
		.CH_W     (CH_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.ch_sel   (ch_sel)
	);

	wdch_dp #(
		.CHANNELS (CHANNELS),
		.CH_W     (CH_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.ch_sel     (ch_sel),
		.sts        (sts),
		.pin_levels (s_tdata[PIN_W-1:0]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

FILE: sv/wdch_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for window length and hysteresis thresholds.
// ----------------------------------------------------------------------------
module wdch_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wdch_pkg::APB_AW-1:0] paddr,
	input  logic [wdch_pkg::APB_DW-1:0] pwdata,
	output logic [wdch_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output wdch_pkg::cfg_t             cfg
);
	import wdch_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window       <= WINDOW_RST;
			cfg_q.on_pct       <= ON_RST;
			cfg_q.off_pct      <= OFF_RST;
			cfg_q.full_on_pct  <= FULL_ON_RST;
			cfg_q.full_off_pct <= FULL_OFF_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_WINDOW:   cfg_q.window       <= pwdata[CNT_W-1:0];
				REG_ON:       cfg_q.on_pct       <= pwdata[PCT_W-1:0];
				REG_OFF:      cfg_q.off_pct      <= pwdata[PCT_W-1:0];
				REG_FULL_ON:  cfg_q.full_on_pct  <= pwdata[PCT_W-1:0];
				REG_FULL_OFF: cfg_q.full_off_pct <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WINDOW:   prdata = APB_DW'(cfg_q.window);
			REG_ON:       prdata = APB_DW'(cfg_q.on_pct);
			REG_OFF:      prdata = APB_DW'(cfg_q.off_pct);
			REG_FULL_ON:  prdata = APB_DW'(cfg_q.full_on_pct);
			REG_FULL_OFF: prdata = APB_DW'(cfg_q.full_off_pct);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: sv/wdch_ctrl.sv
// ----------------------------------------------------------------------------
// Duty-cycle controller
// Sequences sample accept, per-channel serial division, store and output.
// ----------------------------------------------------------------------------
module wdch_ctrl #(
	parameter int CHANNELS = wdch_pkg::CHANNELS_DEF,
	parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  wdch_pkg::sts_t sts,
	output wdch_pkg::cmd_t cmd,
	output logic [CH_W-1:0] ch_sel
);
	import wdch_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ITER,
		ST_STORE,
		ST_PUSH
	} state_t;

	state_t          state_q;
	logic [CH_W-1:0] ch_q;
	logic [BIT_W-1:0] bit_q;
	logic            done_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign ch_sel     = ch_q;
	assign cmd.accept = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.step   = (state_q == ST_ITER);
	assign cmd.store  = (state_q == ST_STORE);
	assign cmd.push   = (state_q == ST_PUSH) && sts.out_free;
	assign cmd.done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						done_q <= sts.close_hit;
						ch_q   <= '0;
						state_q <= sts.close_hit ? ST_LOAD : ST_PUSH;
					end
				end
				ST_LOAD: begin
					bit_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (bit_q == BIT_W'(DVD_W - 1)) begin
						state_q <= ST_STORE;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_STORE: begin
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						state_q <= ST_PUSH;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_PUSH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/wdch_dp.sv
// ----------------------------------------------------------------------------
// Duty-cycle datapath
// High-sample counters, restoring divider, hysteresis flags, output register.
// ----------------------------------------------------------------------------
module wdch_dp #(
	parameter int CHANNELS = wdch_pkg::CHANNELS_DEF,
	parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wdch_pkg::cfg_t                  cfg,
	input  wdch_pkg::cmd_t                  cmd,
	input  logic [CH_W-1:0]                 ch_sel,
	output wdch_pkg::sts_t                  sts,
	input  logic [wdch_pkg::PIN_W-1:0]      pin_levels,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wdch_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]                      m_tuser
);
	import wdch_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  hc_q   [CHANNELS];
	logic [DUTY_W-1:0] duty_q [CHANNELS];
	logic [CHANNELS-1:0] act_q;
	logic [CHANNELS-1:0] full_q;

	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [OUT_TDATA_W-1:0] tdata_q;
	logic                   tuser_q;
	logic                   tvalid_q;

	logic [CHANNELS-1:0] pin_ext;
	logic [CNT_W-1:0]    win_eff;
	logic [CNT_W-1:0]    cnt_inc;
	logic [DVD_W-1:0]    prod;
	logic [CNT_W:0]      rem_sh;
	logic                rem_ge;
	logic [DUTY_W-1:0]   duty_new;
	logic                act_new;
	logic                full_new;
	logic [OUT_TDATA_W-1:0] pack;

	genvar g;
	generate
		for (g = 0; g < CHANNELS; g++) begin : g_pin
			if (g < OUT_CHANS) begin : g_real
				assign pin_ext[g] = pin_levels[g];
			end else begin : g_low
				assign pin_ext[g] = 1'b0;
			end
		end
	endgenerate

	assign win_eff = (cfg.window == '0) ? CNT_W'(1) : cfg.window;
	assign cnt_inc = cnt_q + 1'b1;
	assign sts.close_hit = (cnt_inc >= win_eff) || (cnt_inc == '0);
	assign sts.out_free  = !tvalid_q || m_tready;

	assign prod   = DVD_W'(hc_q[ch_sel]) * DVD_W'(PCT_SCALE);
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, win_eff};

	assign duty_new = (quo_q > DVD_W'(PCT_SCALE)) ? DUTY_W'(PCT_SCALE) : quo_q[DUTY_W-1:0];
	assign act_new  = act_q[ch_sel] ? !(duty_new <= cfg.off_pct) : (duty_new >= cfg.on_pct);
	assign full_new = full_q[ch_sel] ? !(duty_new <= cfg.full_off_pct)
	                                 : (duty_new >= cfg.full_on_pct);

	generate
		for (g = 0; g < OUT_CHANS; g++) begin : g_pack
			if (g < CHANNELS) begin : g_on
				assign pack[g*DUTY_W +: DUTY_W]             = duty_q[g];
				assign pack[OUT_CHANS*DUTY_W + g]           = act_q[g];
				assign pack[OUT_CHANS*DUTY_W + OUT_CHANS + g] = full_q[g];
			end else begin : g_off
				assign pack[g*DUTY_W +: DUTY_W]             = '0;
				assign pack[OUT_CHANS*DUTY_W + g]           = 1'b0;
				assign pack[OUT_CHANS*DUTY_W + OUT_CHANS + g] = 1'b0;
			end
		end
		if (OUT_TDATA_W > OUT_PACK_W) begin : g_pad
			assign pack[OUT_TDATA_W-1:OUT_PACK_W] = '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			act_q  <= '0;
			full_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				hc_q[i]   <= '0;
				duty_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (pin_ext[i]) begin
						hc_q[i] <= hc_q[i] + 1'b1;
					end
				end
				cnt_q <= sts.close_hit ? '0 : cnt_inc;
			end
			if (cmd.store) begin
				hc_q[ch_sel]   <= '0;
				duty_q[ch_sel] <= duty_new;
				act_q[ch_sel]  <= act_new;
				full_q[ch_sel] <= full_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= prod;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, win_eff}) : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tdata_q <= pack;
			tuser_q <= cmd.done;
		end
	end

	assign m_tvalid   = tvalid_q;
	assign m_tdata    = tdata_q;
	assign m_tuser[0] = tuser_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!tvalid_q || m_tready))
		else $error("result pushed over a word still waiting");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> tvalid_q)
		else $error("pushed result not presented");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (rem_q < win_eff))
		else $error("divider remainder not below window");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load, cmd.step, cmd.store, cmd.push}))
		else $error("overlapping datapath commands");

endmodule
